@@ hw/rtl/ethdns_pkg.sv @@
// Shared types and constants for the Ethernet/IPv4/UDP header parser with DNS name walk.
// No dependencies; the parser, result queue and top level refer to it by scoped names.
package ethdns_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 65535;
  localparam int QUEUE_DEPTH         = 4;

  localparam logic [15:0] DNS_PORT_RESET = 16'd53;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [7:0]  PTR_MARK       = 8'hC0;
  localparam logic [7:0]  CHAR_LOW       = 8'd32;
  localparam logic [7:0]  CHAR_HIGH      = 8'd126;
  localparam logic [7:0]  CHAR_DOT       = 8'h2E;
  localparam logic [6:0]  ETH_HDR_BYTES  = 7'd14;
  localparam logic [6:0]  UDP_DNS_HDR    = 7'd20;

  localparam logic KIND_CHAR    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  name_char;
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [7:0]  ip_protocol;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic        ports_valid;
    logic        name_walked;
    logic        last_of_frame;
  } result_t;

  typedef struct packed {
    logic    valid0;
    logic    valid1;
    result_t item0;
    result_t item1;
  } push_t;

  typedef struct packed {
    logic [$clog2(QUEUE_DEPTH+1)-1:0] count;
  } queue_status_t;

endpackage

@@ hw/rtl/ethdns_ifs.sv @@
// Valid/ready channel interfaces: frame bytes in, results out, configuration writes.
// Depends on nothing; the top level eth_ipv4_header_dns_name_parser_core uses all three.
interface ethdns_byte_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [15:0] capture_length;
  logic        end_of_frame;

  modport source (output valid, data_byte, capture_length, end_of_frame, input ready);
  modport sink   (input valid, data_byte, capture_length, end_of_frame, output ready);
endinterface

interface ethdns_result_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  name_char;
  logic [47:0] dest_mac;
  logic [47:0] source_mac;
  logic [31:0] source_ip;
  logic [31:0] dest_ip;
  logic [7:0]  ip_protocol;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic        ports_valid;
  logic        name_walked;
  logic        last_of_frame;

  modport source (output valid, result_kind, name_char, dest_mac, source_mac, source_ip,
                  dest_ip, ip_protocol, source_port, dest_port, ports_valid, name_walked,
                  last_of_frame, input ready);
  modport sink   (input valid, result_kind, name_char, dest_mac, source_mac, source_ip,
                  dest_ip, ip_protocol, source_port, dest_port, ports_valid, name_walked,
                  last_of_frame, output ready);
endinterface

interface ethdns_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] name_service_port;

  modport source (output valid, name_service_port, input ready);
  modport sink   (input valid, name_service_port, output ready);
endinterface

@@ hw/rtl/ethdns_parser.sv @@
// Per-byte frame parser: field capture at fixed offsets and the DNS query name walk.
// Depends on ethdns_pkg; produces up to two results per byte as a push_t.
module ethdns_parser #(
  parameter int MAX_FRAME_BYTES = ethdns_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic [7:0]          data_byte,
  input  logic [15:0]         capture_length,
  input  logic                end_of_frame,
  input  logic [15:0]         service_port,
  output ethdns_pkg::push_t   push
);

  localparam int PosW = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [PosW-1:0] PosMax = PosW'(MAX_FRAME_BYTES);
  localparam logic [15:0]     CapMax = 16'(MAX_FRAME_BYTES);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_LEN   = 2'd1;
  localparam logic [1:0] PH_LABEL = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  logic [PosW-1:0] byte_position, byte_position_next;
  logic [47:0]     dest_mac, dest_mac_next;
  logic [47:0]     source_mac, source_mac_next;
  logic [3:0]      header_words, header_words_next;
  logic [7:0]      protocol, protocol_next;
  logic [31:0]     source_ip, source_ip_next;
  logic [31:0]     dest_ip, dest_ip_next;
  logic [15:0]     source_port, source_port_next;
  logic [15:0]     dest_port, dest_port_next;
  logic [1:0]      walk_phase, walk_phase_next;
  logic [7:0]      label_remaining, label_remaining_next;
  logic            name_started, name_started_next;

  logic            first;
  logic [16:0]     p17;
  logic [15:0]     cap;
  logic [6:0]      port_off, name_off;
  logic            port_match, walked, ports_ok;
  logic            emit;
  logic [7:0]      emit_char;
  logic [7:0]      rem_dec;
  ethdns_pkg::result_t char_res, sum_res;

  always_comb begin
    first = (byte_position == '0);
    p17   = 17'(byte_position);
    cap   = (capture_length > CapMax) ? CapMax : capture_length;

    // Start each frame from cleared fields
    dest_mac_next        = first ? '0 : dest_mac;
    source_mac_next      = first ? '0 : source_mac;
    header_words_next    = first ? '0 : header_words;
    protocol_next        = first ? '0 : protocol;
    source_ip_next       = first ? '0 : source_ip;
    dest_ip_next         = first ? '0 : dest_ip;
    source_port_next     = first ? '0 : source_port;
    dest_port_next       = first ? '0 : dest_port;
    walk_phase_next      = first ? PH_IDLE : walk_phase;
    label_remaining_next = first ? '0 : label_remaining;
    name_started_next    = first ? 1'b0 : name_started;

    if (p17 < 17'd6) begin
      dest_mac_next = {dest_mac_next[39:0], data_byte};
    end else if (p17 < 17'd12) begin
      source_mac_next = {source_mac_next[39:0], data_byte};
    end
    if (p17 == 17'd14) begin
      header_words_next = data_byte[3:0];
    end
    if (p17 == 17'd23) begin
      protocol_next = data_byte;
    end
    if (p17 >= 17'd26 && p17 < 17'd30) begin
      source_ip_next = {source_ip_next[23:0], data_byte};
    end
    if (p17 >= 17'd30 && p17 < 17'd34) begin
      dest_ip_next = {dest_ip_next[23:0], data_byte};
    end

    port_off = ethdns_pkg::ETH_HDR_BYTES + {1'b0, header_words_next, 2'b00};
    name_off = port_off + ethdns_pkg::UDP_DNS_HDR;
    if (p17 >= 17'(port_off) && p17 < 17'(port_off) + 17'd2) begin
      source_port_next = {source_port_next[7:0], data_byte};
    end else if (p17 >= 17'(port_off) + 17'd2 && p17 < 17'(port_off) + 17'd4) begin
      dest_port_next = {dest_port_next[7:0], data_byte};
    end

    port_match = (source_port_next == service_port) || (dest_port_next == service_port);
    walked     = (protocol_next == ethdns_pkg::PROTO_UDP) && port_match
                 && (cap >= 16'(name_off));
    ports_ok   = (protocol_next == ethdns_pkg::PROTO_TCP)
                 || (protocol_next == ethdns_pkg::PROTO_UDP);

    if (walk_phase_next == PH_IDLE && p17 == 17'(name_off) && walked) begin
      walk_phase_next = PH_LEN;
    end

    emit      = 1'b0;
    emit_char = data_byte;
    rem_dec   = label_remaining_next - 8'd1;
    case (walk_phase_next)
      PH_LEN: begin
        if (p17 >= 17'(cap) || data_byte == 8'd0
            || (data_byte & ethdns_pkg::PTR_MARK) == ethdns_pkg::PTR_MARK) begin
          walk_phase_next = PH_DONE;
        end else if (p17 + 17'd1 + 17'(data_byte) <= 17'(cap)) begin
          // Dot goes before every label after the first printed character
          emit                 = name_started_next;
          emit_char            = ethdns_pkg::CHAR_DOT;
          walk_phase_next      = PH_LABEL;
          label_remaining_next = data_byte;
        end else begin
          walk_phase_next = PH_DONE;
        end
      end
      PH_LABEL: begin
        if (data_byte >= ethdns_pkg::CHAR_LOW && data_byte <= ethdns_pkg::CHAR_HIGH) begin
          emit              = 1'b1;
          name_started_next = 1'b1;
        end
        label_remaining_next = rem_dec;
        if (rem_dec == 8'd0) begin
          walk_phase_next = PH_LEN;
        end
      end
      default: begin
      end
    endcase

    if (end_of_frame) begin
      byte_position_next = '0;
    end else if (byte_position < PosMax) begin
      byte_position_next = byte_position + 1'b1;
    end else begin
      byte_position_next = byte_position;
    end

    char_res             = '0;
    char_res.result_kind = ethdns_pkg::KIND_CHAR;
    char_res.name_char   = emit_char;

    sum_res               = '0;
    sum_res.result_kind   = ethdns_pkg::KIND_SUMMARY;
    sum_res.dest_mac      = dest_mac_next;
    sum_res.source_mac    = source_mac_next;
    sum_res.source_ip     = source_ip_next;
    sum_res.dest_ip       = dest_ip_next;
    sum_res.ip_protocol   = protocol_next;
    sum_res.source_port   = ports_ok ? source_port_next : 16'd0;
    sum_res.dest_port     = ports_ok ? dest_port_next : 16'd0;
    sum_res.ports_valid   = ports_ok;
    sum_res.name_walked   = walked;
    sum_res.last_of_frame = 1'b1;

    push.valid0 = advance && (emit || end_of_frame);
    push.valid1 = advance && emit && end_of_frame;
    push.item0  = emit ? char_res : sum_res;
    push.item1  = sum_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
    end else if (advance) begin
      byte_position <= byte_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dest_mac        <= dest_mac_next;
      source_mac      <= source_mac_next;
      header_words    <= header_words_next;
      protocol        <= protocol_next;
      source_ip       <= source_ip_next;
      dest_ip         <= dest_ip_next;
      source_port     <= source_port_next;
      dest_port       <= dest_port_next;
      walk_phase      <= walk_phase_next;
      label_remaining <= label_remaining_next;
      name_started    <= name_started_next;
    end
  end

endmodule

@@ hw/rtl/ethdns_result_queue.sv @@
// Small result queue taking up to two ordered results per cycle, releasing one per cycle on pop.
// Depends on ethdns_pkg for result_t, push_t and queue_status_t.
module ethdns_result_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  ethdns_pkg::push_t           push,
  input  logic                        pop,
  output logic                        head_valid,
  output ethdns_pkg::result_t         head,
  output ethdns_pkg::queue_status_t   status
);

  localparam int Depth = ethdns_pkg::QUEUE_DEPTH;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  ethdns_pkg::result_t mem [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic [PtrW-1:0] wr_ptr_b;
  logic [CntW-1:0] n_push;
  logic            do_pop;

  always_comb begin
    wr_ptr_b   = wr_ptr + 1'b1;
    n_push     = CntW'(push.valid0) + CntW'(push.valid1);
    do_pop     = pop && (count != '0);
    head_valid = (count != '0);
    head       = mem[rd_ptr];
    status.count = count;
  end

  always_ff @(posedge clk) begin
    if (push.valid0) begin
      mem[wr_ptr] <= push.item0;
    end
    if (push.valid1) begin
      mem[wr_ptr_b] <= push.item1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrW'(n_push);
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + n_push - CntW'(do_pop);
    end
  end

endmodule

@@ hw/rtl/eth_ipv4_header_dns_name_parser_core.sv @@
// Top level of the Ethernet/IPv4/UDP header parser with DNS query name extraction.
// Depends on ethdns_pkg, ethdns_ifs (channel interfaces), ethdns_parser, ethdns_result_queue.
//
// Usage:
//   frame  : one captured frame byte per transaction, with the frame's capture length and
//            an end flag on the last byte. The next byte after the end flag starts a new frame.
//   result : name characters (kind 0, dots between labels) and one summary (kind 1) per
//            frame, carrying MACs, IPv4 addresses, protocol, ports and flags.
//   cfg    : writes name_service_port, the UDP port that marks DNS traffic (reset 53).
//            Write it only while no frame bytes are in flight.
// Path: a taken byte is held in the input register, processed by the parser and written into
//   the result queue; its results are offered on the result channel from the queue head.
// Throughput: one byte per cycle while the result queue has room. A frame's last byte that
//   also yields a name character makes two results; the four-entry result queue absorbs
//   the extra one, since the output channel moves one result per cycle.
// Stalls: when the receiver holds ready low the queue fills and frame.ready drops once
//   fewer than two entries are free; nothing is lost.
// Reset: synchronous, active high; clears the byte position, queue and input valid flag,
//   and returns name_service_port to 53.
module eth_ipv4_header_dns_name_parser_core #(
  parameter int MAX_FRAME_BYTES = ethdns_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  ethdns_byte_if.sink            frame,
  ethdns_result_if.source        result,
  ethdns_cfg_if.sink             cfg
);

  localparam int Depth = ethdns_pkg::QUEUE_DEPTH;
  localparam int CntW  = $clog2(Depth + 1);

  logic        in_valid;
  logic [7:0]  in_data_byte;
  logic [15:0] in_capture_length;
  logic        in_end_of_frame;
  logic [15:0] service_port;
  logic        room;
  logic        advance;

  ethdns_pkg::push_t         push;
  ethdns_pkg::result_t       head;
  ethdns_pkg::queue_status_t q_status;
  logic                      head_valid;

  assign room        = (q_status.count <= CntW'(Depth - 2));
  assign advance     = in_valid && room;
  assign frame.ready = !in_valid || room;
  assign cfg.ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (frame.ready) begin
      in_valid <= frame.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.ready && frame.valid) begin
      in_data_byte      <= frame.data_byte;
      in_capture_length <= frame.capture_length;
      in_end_of_frame   <= frame.end_of_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      service_port <= ethdns_pkg::DNS_PORT_RESET;
    end else if (cfg.valid) begin
      service_port <= cfg.name_service_port;
    end
  end

  ethdns_parser #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parser (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .data_byte     (in_data_byte),
    .capture_length(in_capture_length),
    .end_of_frame  (in_end_of_frame),
    .service_port  (service_port),
    .push          (push)
  );

  ethdns_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (result.ready),
    .head_valid(head_valid),
    .head      (head),
    .status    (q_status)
  );

  assign result.valid         = head_valid;
  assign result.result_kind   = head.result_kind;
  assign result.name_char     = head.name_char;
  assign result.dest_mac      = head.dest_mac;
  assign result.source_mac    = head.source_mac;
  assign result.source_ip     = head.source_ip;
  assign result.dest_ip       = head.dest_ip;
  assign result.ip_protocol   = head.ip_protocol;
  assign result.source_port   = head.source_port;
  assign result.dest_port     = head.dest_port;
  assign result.ports_valid   = head.ports_valid;
  assign result.name_walked   = head.name_walked;
  assign result.last_of_frame = head.last_of_frame;

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_status.count <= CntW'(Depth))
    else $error("result queue count beyond depth");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    advance |-> q_status.count <= CntW'(Depth - 2))
    else $error("byte processed without room for two results");

  a_summary_out: assert property (@(posedge clk) disable iff (rst)
    (advance && in_end_of_frame) |=> result.valid)
    else $error("frame end produced no queued summary");

  a_summary_kind: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.last_of_frame) |-> result.result_kind)
    else $error("frame summary carries character kind");

endmodule
